@@ sv/sqsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher package
// Sizes, codes and shared types of the dispatcher.
// ----------------------------------------------------------------------------
package sqsd_pkg;

	localparam int SRV_CNT     = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_WIDTH   = 16;

	localparam int SRV_W   = $clog2(SRV_CNT);
	localparam int NSRV_W  = $clog2(SRV_CNT + 1);
	localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = SRV_W + SLOT_W;
	localparam int DROP_W  = 32;
	localparam int CFG_AW  = 5;
	localparam int CFG_DW  = 32;

	typedef enum logic [2:0] {
		OUT_STARTED,
		OUT_QUEUED,
		OUT_DROPPED,
		OUT_DONE_IDLE,
		OUT_DONE_NEXT,
		OUT_ERROR
	} outcome_t;

	typedef enum logic {
		OP_ARRIVAL,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		REG_SERVERS,
		REG_LIMIT0,
		REG_LIMIT1,
		REG_LIMIT2,
		REG_LIMIT3
	} reg_idx_t;

	typedef struct packed {
		logic [NSRV_W-1:0]              servers_in_use;
		logic [SRV_CNT-1:0][CNT_W-1:0]  queue_limit;
	} cfg_t;

endpackage

@@ sv/sqsd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher channels
// Event channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface sqsd_evt_if;
	import sqsd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [SRV_W-1:0]     done_srv;
	logic [TAG_WIDTH-1:0] job_tag;

	modport source (output valid, op, done_srv, job_tag, input ready);
	modport sink (input valid, op, done_srv, job_tag, output ready);
endinterface

interface sqsd_res_if;
	import sqsd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [2:0]           outcome;
	logic [SRV_W-1:0]     srv_id;
	logic [TAG_WIDTH-1:0] finished_tag;
	logic [TAG_WIDTH-1:0] started_tag;
	logic [CNT_W-1:0]     queue_length;
	logic [DROP_W-1:0]    drop_total;

	modport source (output valid, outcome, srv_id, finished_tag, started_tag,
		queue_length, drop_total, input ready);
	modport sink (input valid, outcome, srv_id, finished_tag, started_tag,
		queue_length, drop_total, output ready);
endinterface

@@ sv/sqsd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher register file
// APB-style configuration registers: servers in use and per-server limits.
// ----------------------------------------------------------------------------
module sqsd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sqsd_pkg::CFG_AW-1:0]   paddr,
	input  logic [sqsd_pkg::CFG_DW-1:0]   pwdata,
	output logic [sqsd_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	output sqsd_pkg::cfg_t                cfg
);
	import sqsd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.servers_in_use <= NSRV_W'(SRV_CNT);
			for (int i = 0; i < SRV_CNT; i++) begin
				cfg_q.queue_limit[i] <= CNT_W'(QUEUE_DEPTH);
			end
		end else if (wr) begin
			unique case (idx)
				REG_SERVERS: cfg_q.servers_in_use <= pwdata[NSRV_W-1:0];
				REG_LIMIT0:  cfg_q.queue_limit[0] <= pwdata[CNT_W-1:0];
				REG_LIMIT1:  cfg_q.queue_limit[1] <= pwdata[CNT_W-1:0];
				REG_LIMIT2:  cfg_q.queue_limit[2] <= pwdata[CNT_W-1:0];
				REG_LIMIT3:  cfg_q.queue_limit[3] <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SERVERS: prdata = CFG_DW'(cfg_q.servers_in_use);
			REG_LIMIT0:  prdata = CFG_DW'(cfg_q.queue_limit[0]);
			REG_LIMIT1:  prdata = CFG_DW'(cfg_q.queue_limit[1]);
			REG_LIMIT2:  prdata = CFG_DW'(cfg_q.queue_limit[2]);
			REG_LIMIT3:  prdata = CFG_DW'(cfg_q.queue_limit[3]);
			default:     prdata = '0;
		endcase
	end
endmodule

@@ sv/sqsd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher core
// Input register, dispatch decision, server state, wait memory, result register.
// ----------------------------------------------------------------------------
module sqsd_core (
	input  logic            clk,
	input  logic            arst_n,
	input  sqsd_pkg::cfg_t  cfg,
	sqsd_evt_if.sink        evt,
	sqsd_res_if.source      res
);
	import sqsd_pkg::*;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [SRV_W-1:0]     target_s1;
	logic [TAG_WIDTH-1:0] tag_s1;

	logic                 valid_s2;
	outcome_t             outcome_s2;
	logic [SRV_W-1:0]     server_s2;
	logic [TAG_WIDTH-1:0] fin_s2;
	logic [TAG_WIDTH-1:0] start_s2;
	logic                 start_mem_s2;
	logic [CNT_W-1:0]     qlen_s2;
	logic [DROP_W-1:0]    drop_s2;
	logic [TAG_WIDTH-1:0] rd_data_s2;

	logic [SRV_CNT-1:0]                busy_q;
	logic [CNT_W-1:0]                  count_q   [SRV_CNT];
	logic [SLOT_W-1:0]                 head_q    [SRV_CNT];
	logic [TAG_WIDTH-1:0]              serving_q [SRV_CNT];
	logic [DROP_W-1:0]                 drop_q;
	logic                              pend_q;
	logic [SRV_W-1:0]                  pend_srv_q;

	logic [TAG_WIDTH-1:0] mem [SRV_CNT*QUEUE_DEPTH];

	logic                 adv;
	logic [NSRV_W-1:0]    n_act;
	logic [SRV_W-1:0]     pick;
	logic [SRV_W-1:0]     sel;
	logic [CNT_W-1:0]     lim;
	logic [CNT_W-1:0]     cnt_sel;
	logic [TAG_WIDTH-1:0] fin_tag;
	logic [DROP_W-1:0]    drop_nxt;
	logic                 do_start, do_queue, do_drop, do_idle, do_next;
	outcome_t             outcome;
	logic [CNT_W-1:0]     qlen;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr;

	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_s1     <= op_t'(evt.op);
			target_s1 <= evt.done_srv;
			tag_s1    <= evt.job_tag;
		end
	end

	always_comb begin
		if (cfg.servers_in_use == '0) begin
			n_act = NSRV_W'(1);
		end else if (cfg.servers_in_use > NSRV_W'(SRV_CNT)) begin
			n_act = NSRV_W'(SRV_CNT);
		end else begin
			n_act = cfg.servers_in_use;
		end
		pick = '0;
		for (int i = 1; i < SRV_CNT; i++) begin
			if (NSRV_W'(i) < n_act && count_q[i] < count_q[pick]) begin
				pick = SRV_W'(i);
			end
		end
		for (int i = 0; i < SRV_CNT; i++) begin
			if (NSRV_W'(i) < n_act && !busy_q[i]) begin
				pick = SRV_W'(i);
			end
		end
	end

	assign sel     = (op_s1 == OP_ARRIVAL) ? pick : target_s1;
	assign cnt_sel = count_q[sel];
	assign lim     = (cfg.queue_limit[sel] > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
		: cfg.queue_limit[sel];
	assign fin_tag = (pend_q && pend_srv_q == sel) ? rd_data_s2 : serving_q[sel];
	assign drop_nxt = (drop_q != '1) ? drop_q + DROP_W'(1) : drop_q;
	assign wr_addr = {sel, SLOT_W'(CNT_W'(head_q[sel]) + cnt_sel)};
	assign rd_addr = {sel, head_q[sel]};

	always_comb begin
		do_start = 1'b0;
		do_queue = 1'b0;
		do_drop  = 1'b0;
		do_idle  = 1'b0;
		do_next  = 1'b0;
		outcome  = OUT_ERROR;
		qlen     = cnt_sel;
		unique case (op_s1)
			OP_ARRIVAL: begin
				priority if (!busy_q[sel]) begin
					do_start = 1'b1;
					outcome  = OUT_STARTED;
				end else if (cnt_sel < lim) begin
					do_queue = 1'b1;
					outcome  = OUT_QUEUED;
					qlen     = cnt_sel + CNT_W'(1);
				end else begin
					do_drop  = 1'b1;
					outcome  = OUT_DROPPED;
				end
			end
			OP_DONE: begin
				priority if (!busy_q[sel]) begin
					outcome = OUT_ERROR;
				end else if (cnt_sel == '0) begin
					do_idle = 1'b1;
					outcome = OUT_DONE_IDLE;
					qlen    = '0;
				end else begin
					do_next = 1'b1;
					outcome = OUT_DONE_NEXT;
					qlen    = cnt_sel - CNT_W'(1);
				end
			end
			default: outcome = OUT_ERROR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			drop_q     <= '0;
			pend_q     <= 1'b0;
			pend_srv_q <= '0;
			valid_s2   <= 1'b0;
			for (int i = 0; i < SRV_CNT; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else begin
			pend_q <= adv && do_next;
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
			if (adv) begin
				if (do_next) begin
					pend_srv_q   <= sel;
					head_q[sel]  <= head_q[sel] + SLOT_W'(1);
					count_q[sel] <= cnt_sel - CNT_W'(1);
				end
				if (do_start) begin
					busy_q[sel] <= 1'b1;
				end
				if (do_idle) begin
					busy_q[sel] <= 1'b0;
				end
				if (do_queue) begin
					count_q[sel] <= cnt_sel + CNT_W'(1);
				end
				if (do_drop) begin
					drop_q <= drop_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			serving_q[pend_srv_q] <= rd_data_s2;
		end
		if (adv && do_start) begin
			serving_q[sel] <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && do_queue) begin
			mem[wr_addr] <= tag_s1;
		end
		if (adv && do_next) begin
			rd_data_s2 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			outcome_s2   <= outcome;
			server_s2    <= sel;
			fin_s2       <= (do_idle || do_next) ? fin_tag : '0;
			start_s2     <= do_start ? tag_s1 : '0;
			start_mem_s2 <= do_next;
			qlen_s2      <= qlen;
			drop_s2      <= do_drop ? drop_nxt : drop_q;
		end
	end

	assign res.valid        = valid_s2;
	assign res.outcome      = outcome_s2;
	assign res.srv_id       = server_s2;
	assign res.finished_tag = fin_s2;
	assign res.started_tag  = start_mem_s2 ? rd_data_s2 : start_s2;
	assign res.queue_length = qlen_s2;
	assign res.drop_total   = drop_s2;
endmodule

@@ sv/shortest_queue_server_dispatcher.sv @@
`timescale 1ns / 1ps
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless the result channel stalls; the wait
// memory read of a completion lands in the result register and is forwarded
// to the next completion at the same server.
// Reset: asynchronous, active low; all servers idle, queues empty, drop count zero,
// registers at four servers and limit 16. No clearing pass.
// ----------------------------------------------------------------------------
// Shortest-queue server dispatcher
// Join-shortest-queue dispatch of jobs over four servers with bounded queues.
// ----------------------------------------------------------------------------
module shortest_queue_server_dispatcher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sqsd_pkg::CFG_AW-1:0]   paddr,
	input  logic [sqsd_pkg::CFG_DW-1:0]   pwdata,
	output logic [sqsd_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	sqsd_evt_if.sink                      evt,
	sqsd_res_if.source                    res
);
	import sqsd_pkg::*;

	cfg_t cfg;

	sqsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sqsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.evt    (evt),
		.res    (res)
	);
endmodule

@@ sv/sqsd_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sqsd_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             res_valid,
	input logic                             res_ready,
	input logic [2:0]                       res_outcome,
	input logic [sqsd_pkg::TAG_WIDTH-1:0]   res_started_tag,
	input logic [sqsd_pkg::CNT_W-1:0]       res_queue_length,
	input logic [sqsd_pkg::DROP_W-1:0]      res_drop_total
);
	import sqsd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_outcome)
			&& $stable(res_started_tag) && $stable(res_drop_total))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_outcome <= OUT_ERROR && res_queue_length <= CNT_W'(QUEUE_DEPTH))
		else $error("outcome or queue length out of range");

	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_outcome == OUT_DONE_IDLE |-> res_queue_length == '0
			&& res_started_tag == '0)
		else $error("idle completion with waiting jobs");

	a_queued: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_outcome == OUT_QUEUED |-> res_queue_length != '0)
		else $error("queued item with empty queue");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_outcome == OUT_DROPPED |-> res_drop_total != '0)
		else $error("drop without drop count");
endmodule

bind shortest_queue_server_dispatcher sqsd_check u_sqsd_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_outcome      (res.outcome),
	.res_started_tag  (res.started_tag),
	.res_queue_length (res.queue_length),
	.res_drop_total   (res.drop_total)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-queue dispatcher testbench
// Drives arrivals and completions over the event channel and checks each
// result against a typed table row or an in-bench dispatcher model. A
// directed table covers reset, idle-server override, tie breaks, zero and
// oversized limits and completions at idle servers. Random phases with
// fresh register settings follow, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import sqsd_pkg::*;

	localparam int LATENCY     = 2;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		outcome_t             outcome;
		logic [SRV_W-1:0]     server;
		logic [TAG_WIDTH-1:0] fin;
		logic [TAG_WIDTH-1:0] start;
		logic [CNT_W-1:0]     qlen;
		logic [DROP_W-1:0]    drops;
	} disp_res_t;

	typedef struct {
		bit                   is_cfg;
		reg_idx_t             cfg_reg;
		logic [CFG_DW-1:0]    cfg_val;
		op_t                  op;
		logic [SRV_W-1:0]     tgt;
		logic [TAG_WIDTH-1:0] tag;
		bit                   typed;
		disp_res_t            want;
	} stim_row_t;

	typedef struct {
		bit        typed;
		disp_res_t want;
	} sent_note_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	sqsd_evt_if evt_ch();
	sqsd_res_if res_ch();

	shortest_queue_server_dispatcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.evt(evt_ch),
		.res(res_ch)
	);

	// dispatcher model state
	logic [NSRV_W-1:0]    srv_cfg;
	logic [CNT_W-1:0]     limit_cfg [SRV_CNT];
	logic [TAG_WIDTH-1:0] wait_tags [SRV_CNT][QUEUE_DEPTH];
	int                   head_slot [SRV_CNT];
	int                   wait_cnt [SRV_CNT];
	bit                   busy [SRV_CNT];
	logic [TAG_WIDTH-1:0] serving [SRV_CNT];
	logic [DROP_W-1:0]    drops;

	disp_res_t  pending_results [$];
	sent_note_t sent_notes [$];
	stim_row_t  plan [$];
	sent_note_t note;
	disp_res_t  modeled;
	int         mismatches;
	int         cycle_cnt;
	bit         idle_on;
	int         stall_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic disp_res_t predict_dispatch(op_t op, logic [SRV_W-1:0] tgt,
		logic [TAG_WIDTH-1:0] tag);
		disp_res_t r;
		int n;
		int pick;
		int lim;
		int slot;
		r = '0;
		if (op == OP_ARRIVAL) begin
			n = (srv_cfg == 0) ? 1 : ((srv_cfg > SRV_CNT) ? SRV_CNT : int'(srv_cfg));
			pick = 0;
			for (int i = 1; i < n; i++)
				if (wait_cnt[i] < wait_cnt[pick]) pick = i;
			for (int i = 0; i < n; i++)
				if (!busy[i]) pick = i;
			lim = (limit_cfg[pick] > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_cfg[pick]);
			r.server = SRV_W'(pick);
			if (!busy[pick]) begin
				busy[pick] = 1'b1;
				serving[pick] = tag;
				r.outcome = OUT_STARTED;
				r.start = tag;
			end else if (wait_cnt[pick] < lim) begin
				slot = (head_slot[pick] + wait_cnt[pick]) % QUEUE_DEPTH;
				wait_tags[pick][slot] = tag;
				wait_cnt[pick]++;
				r.outcome = OUT_QUEUED;
			end else begin
				if (drops != '1) drops++;
				r.outcome = OUT_DROPPED;
			end
			r.qlen = CNT_W'(wait_cnt[pick]);
		end else if (!busy[tgt]) begin
			r.outcome = OUT_ERROR;
			r.server = tgt;
			r.qlen = CNT_W'(wait_cnt[tgt]);
		end else begin
			r.server = tgt;
			r.fin = serving[tgt];
			if (wait_cnt[tgt] == 0) begin
				busy[tgt] = 1'b0;
				r.outcome = OUT_DONE_IDLE;
			end else begin
				serving[tgt] = wait_tags[tgt][head_slot[tgt]];
				head_slot[tgt] = (head_slot[tgt] + 1) % QUEUE_DEPTH;
				wait_cnt[tgt]--;
				r.outcome = OUT_DONE_NEXT;
				r.start = serving[tgt];
				r.qlen = CNT_W'(wait_cnt[tgt]);
			end
		end
		r.drops = drops;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result(disp_res_t want);
		check_field("outcome", 32'(want.outcome), 32'(res_ch.outcome));
		check_field("srv_id", 32'(want.server), 32'(res_ch.srv_id));
		check_field("finished_tag", 32'(want.fin), 32'(res_ch.finished_tag));
		check_field("started_tag", 32'(want.start), 32'(res_ch.started_tag));
		check_field("queue_length", 32'(want.qlen), 32'(res_ch.queue_length));
		check_field("drop_total", want.drops, res_ch.drop_total);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, outcome %0d server %0d", $time,
						res_ch.outcome, res_ch.srv_id);
					mismatches++;
				end else begin
					check_result(pending_results.pop_front());
				end
			end
			if (evt_ch.valid && evt_ch.ready) begin
				note = sent_notes.pop_front();
				modeled = predict_dispatch(op_t'(evt_ch.op), evt_ch.done_srv,
					evt_ch.job_tag);
				pending_results.insert(pending_results.size(),
					note.typed ? note.want : modeled);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!idle_on) begin
			res_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 6);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	function automatic disp_res_t mk_res(outcome_t oc, int srv, int fin, int start, int qlen,
		int dr);
		disp_res_t r;
		r.outcome = oc;
		r.server = SRV_W'(srv);
		r.fin = TAG_WIDTH'(fin);
		r.start = TAG_WIDTH'(start);
		r.qlen = CNT_W'(qlen);
		r.drops = DROP_W'(dr);
		return r;
	endfunction

	function automatic void add_evt(op_t op, int tgt, int tag, bit typed, disp_res_t want);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_reg = REG_SERVERS;
		row.cfg_val = '0;
		row.op = op;
		row.tgt = SRV_W'(tgt);
		row.tag = TAG_WIDTH'(tag);
		row.typed = typed;
		row.want = want;
		plan.insert(plan.size(), row);
	endfunction

	function automatic void add_cfg(reg_idx_t idx, int val);
		stim_row_t row;
		row.is_cfg = 1'b1;
		row.cfg_reg = idx;
		row.cfg_val = CFG_DW'(val);
		row.op = OP_ARRIVAL;
		row.tgt = '0;
		row.tag = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.insert(plan.size(), row);
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic cfg_write(reg_idx_t idx, logic [CFG_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_SERVERS) srv_cfg = val[NSRV_W-1:0];
		else limit_cfg[int'(idx) - int'(REG_LIMIT0)] = val[CNT_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// call at a falling edge; returns at a falling edge with valid still high
	task automatic send_event(stim_row_t row);
		sent_note_t n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			evt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		n.typed = row.typed;
		n.want = row.want;
		sent_notes.insert(sent_notes.size(), n);
		evt_ch.valid <= 1'b1;
		evt_ch.op <= row.op;
		evt_ch.done_srv <= row.tgt;
		evt_ch.job_tag <= row.tag;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		evt_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	function automatic int pick_servers();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 7;
			2: return 1;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int pick_limit();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 31;
			2: return 16;
			3: return $urandom_range(17, 31);
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	initial begin
		stim_row_t row;
		int arr_pct;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		evt_ch.valid = 1'b0;
		evt_ch.op = OP_ARRIVAL;
		evt_ch.done_srv = '0;
		evt_ch.job_tag = '0;
		mismatches = 0;
		cycle_cnt = 0;
		idle_on = 1'b1;
		stall_left = 0;

		srv_cfg = NSRV_W'(SRV_CNT);
		drops = '0;
		for (int i = 0; i < SRV_CNT; i++) begin
			limit_cfg[i] = CNT_W'(QUEUE_DEPTH);
			head_slot[i] = 0;
			wait_cnt[i] = 0;
			busy[i] = 1'b0;
			serving[i] = '0;
			for (int j = 0; j < QUEUE_DEPTH; j++) wait_tags[i][j] = '0;
		end

		add_evt(OP_DONE, 0, 16'h1111, 1, mk_res(OUT_ERROR, 0, 0, 0, 0, 0));
		add_evt(OP_DONE, 3, 16'h2222, 1, mk_res(OUT_ERROR, 3, 0, 0, 0, 0));
		add_evt(OP_ARRIVAL, 2, 16'hFFFF, 1, mk_res(OUT_STARTED, 3, 0, 16'hFFFF, 0, 0));
		add_evt(OP_ARRIVAL, 1, 16'h0000, 1, mk_res(OUT_STARTED, 2, 0, 0, 0, 0));
		add_evt(OP_ARRIVAL, 0, 16'h1234, 1, mk_res(OUT_STARTED, 1, 0, 16'h1234, 0, 0));
		add_evt(OP_ARRIVAL, 3, 16'h8001, 1, mk_res(OUT_STARTED, 0, 0, 16'h8001, 0, 0));
		add_evt(OP_ARRIVAL, 0, 16'hAAAA, 1, mk_res(OUT_QUEUED, 0, 0, 0, 1, 0));
		add_evt(OP_ARRIVAL, 0, 16'h5555, 1, mk_res(OUT_QUEUED, 1, 0, 0, 1, 0));
		add_evt(OP_DONE, 3, 16'h0000, 1, mk_res(OUT_DONE_IDLE, 3, 16'hFFFF, 0, 0, 0));
		add_evt(OP_DONE, 0, 16'hFFFF, 1,
			mk_res(OUT_DONE_NEXT, 0, 16'h8001, 16'hAAAA, 0, 0));
		add_evt(OP_DONE, 0, 16'h0000, 1, mk_res(OUT_DONE_IDLE, 0, 16'hAAAA, 0, 0, 0));
		add_cfg(REG_SERVERS, 0);
		add_cfg(REG_LIMIT0, 0);
		add_evt(OP_ARRIVAL, 0, 16'h0F0F, 1, mk_res(OUT_STARTED, 0, 0, 16'h0F0F, 0, 0));
		add_evt(OP_ARRIVAL, 0, 16'hF0F0, 1, mk_res(OUT_DROPPED, 0, 0, 0, 0, 1));
		add_evt(OP_DONE, 1, 16'h0000, 1,
			mk_res(OUT_DONE_NEXT, 1, 16'h1234, 16'h5555, 0, 1));
		add_cfg(REG_SERVERS, 7);
		add_cfg(REG_LIMIT0, 31);
		add_cfg(REG_LIMIT1, 1);
		add_cfg(REG_LIMIT2, 17);
		add_cfg(REG_LIMIT3, 0);
		add_evt(OP_ARRIVAL, 0, 16'h3C3C, 0, '0);
		add_evt(OP_ARRIVAL, 0, 16'hC3C3, 0, '0);
		add_evt(OP_ARRIVAL, 0, 16'h0001, 0, '0);
		add_evt(OP_ARRIVAL, 0, 16'h0002, 0, '0);
		add_evt(OP_ARRIVAL, 0, 16'h0004, 0, '0);
		add_evt(OP_ARRIVAL, 0, 16'h0008, 0, '0);
		add_evt(OP_DONE, 2, 16'h0000, 0, '0);
		add_evt(OP_DONE, 1, 16'h0000, 0, '0);
		add_evt(OP_DONE, 1, 16'h0000, 0, '0);
		add_evt(OP_DONE, 3, 16'h0000, 0, '0);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				cfg_write(plan[i].cfg_reg, plan[i].cfg_val);
			end else begin
				send_event(plan[i]);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			cfg_write(REG_SERVERS, CFG_DW'(pick_servers()));
			cfg_write(REG_LIMIT0, CFG_DW'(pick_limit()));
			cfg_write(REG_LIMIT1, CFG_DW'(pick_limit()));
			cfg_write(REG_LIMIT2, CFG_DW'(pick_limit()));
			cfg_write(REG_LIMIT3, CFG_DW'(pick_limit()));
			idle_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0: arr_pct = 40;
				1: arr_pct = 55;
				2: arr_pct = 70;
				default: arr_pct = 85;
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				row.is_cfg = 1'b0;
				row.cfg_reg = REG_SERVERS;
				row.cfg_val = '0;
				row.typed = 1'b0;
				row.want = '0;
				row.op = ($urandom_range(1, 100) <= arr_pct) ? OP_ARRIVAL : OP_DONE;
				row.tgt = SRV_W'($urandom_range(0, SRV_CNT - 1));
				case ($urandom_range(0, 7))
					0: row.tag = '0;
					1: row.tag = '1;
					default: row.tag = TAG_WIDTH'($urandom);
				endcase
				send_event(row);
			end
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/sqsd_pkg.sv
sv/sqsd_if.sv
sv/sqsd_cfg.sv
sv/sqsd_core.sv
sv/shortest_queue_server_dispatcher.sv
sv/sqsd_check.sv
tb/tb_top.sv
